[rtl/assert_macros.svh]
// Assertion helpers. clk and rst are taken from the scope of the user.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Property must hold at every clock edge outside reset.
`define BAVG_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// Antecedent at one edge implies the consequent at the next edge.
`define BAVG_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define BAVG_ASSERT(lbl, prop, msg)
`define BAVG_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

[rtl/bavg_pkg.sv]
`default_nettype none
package bavg_pkg;

  localparam int unsigned DATA_BITS  = 24;
  localparam int unsigned SUM_W      = 40;
  localparam int unsigned CNT_W      = 16;
  localparam int unsigned HP_W       = 10;
  localparam int unsigned GAIN_W     = 2;
  localparam int unsigned PULSE_W    = 5;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 24;
  localparam int unsigned DIV_CNT_W  = 6;

  localparam logic [DATA_BITS-1:0] FLIP_MASK = 24'h800000;
  localparam logic [DATA_BITS-1:0] MAX24     = 24'hFFFFFF;
  localparam logic [PULSE_W-1:0]   LAST_BIT  = 5'd24;
  localparam logic [DIV_CNT_W-1:0] DIV_LAST  = 6'd39;

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_COUNT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_PULSES  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HALF_PERIOD  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_GAP          = 3'd4;

  // Converter-side sequencing phase
  typedef enum logic [2:0] {
    PH_IDLE  = 3'd0,
    PH_WAIT  = 3'd1,
    PH_DHIGH = 3'd2,
    PH_DLOW  = 3'd3,
    PH_GHIGH = 3'd4,
    PH_GLOW  = 3'd5,
    PH_GAP   = 3'd6
  } phase_t;

  typedef enum logic [1:0] {
    CS_IDLE = 2'd0,
    CS_DIV  = 2'd1,
    CS_LOAD = 2'd2
  } ctrl_state_t;

  typedef struct packed {
    logic dout;
    logic start_req;
  } in_beat_t;

  typedef struct packed {
    logic                 sck;
    logic                 busy_res;
    logic                 result_valid;
    logic [DATA_BITS-1:0] average;
    logic                 any_timeout;
  } out_beat_t;

  typedef struct packed {
    logic step;
    logic div_run;
    logic out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic finish;
    logic div_last;
  } dp_status_t;

endpackage
`default_nettype wire

[rtl/bridge_adc_serial_readout_average.sv]
// Channel | valid     | stall     | payload
// --------+-----------+-----------+-----------------------------------------
// in      | in_valid  | in_stall  | in_data  : dout, start_req (one tick)
// out     | out_valid | out_stall | out_data : sck, busy_res, result_valid,
//         |           |           |            average, any_timeout
// cfg     | cfg_we    | -         | cfg_index, cfg_data (no read-back)
//
// Each input beat is one timebase tick and yields exactly one output beat.
// A tick is accepted, then loaded into the output register; the tick
// that closes an averaging run first has the 40-bit sum divided
// by the sample count in a restoring divider at one quotient bit a cycle.
// Input is taken again while an earlier result still sits in the output
// register; a stalled output holds only the load of the next result.
// rst is synchronous and active high; it restores register defaults.
`default_nettype none
module bridge_adc_serial_readout_average import bavg_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst,
  // input ticks
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire in_beat_t              in_data,
  // per-tick results
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output out_beat_t                  out_data,
  // configuration writes
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  // command and status between sequencer and datapath
  ctrl_cmd_t  cmd;
  dp_status_t status;

  // Sequencer: accepts a beat, runs the divider when a run completes,
  // then drops the result into the output register.
  bavg_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  // Datapath: converter phase tracking, bit shifter, accumulator,
  // divider and the output payload register.
  bavg_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .cmd       (cmd),
    .status    (status),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire

[rtl/bavg_ctrl.sv]
`default_nettype none
`include "assert_macros.svh"
module bavg_ctrl import bavg_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_stall,
  output logic            out_valid,
  input  wire logic       out_stall,
  input  wire dp_status_t status,
  output ctrl_cmd_t       cmd
);

  ctrl_state_t state, state_next;
  logic        out_valid_next;

  always_comb begin
    state_next = state;
    case (state)
      CS_IDLE: begin
        if (in_valid) begin
          state_next = status.finish ? CS_DIV : CS_LOAD;
        end
      end
      CS_DIV: begin
        if (status.div_last) begin
          state_next = CS_LOAD;
        end
      end
      CS_LOAD: begin
        if (!out_valid || !out_stall) begin
          state_next = CS_IDLE;
        end
      end
      default: state_next = CS_IDLE;
    endcase
  end

  always_comb begin
    cmd          = '0;
    in_stall     = 1'b1;
    case (state)
      CS_IDLE: begin
        in_stall = 1'b0;
        cmd.step = in_valid;
      end
      CS_DIV: begin
        cmd.div_run = 1'b1;
      end
      CS_LOAD: begin
        cmd.out_load = !out_valid || !out_stall;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

  assign out_valid_next = cmd.out_load | (out_valid & out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= CS_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  `BAVG_ASSERT(a_load_no_overwrite, !(cmd.out_load && out_valid && out_stall), "result overwritten")
  `BAVG_ASSERT_NEXT(a_div_to_load, state == CS_DIV && status.div_last, state == CS_LOAD, "divide end lost")
  `BAVG_ASSERT_NEXT(a_step_then_busy, cmd.step, in_stall, "second beat taken before result")

endmodule
`default_nettype wire

[rtl/bavg_dp.sv]
`default_nettype none
`include "assert_macros.svh"
module bavg_dp import bavg_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  input  wire in_beat_t              in_data,
  input  wire ctrl_cmd_t             cmd,
  output dp_status_t                 status,
  output out_beat_t                  out_data
);

  // configuration
  logic [CNT_W-1:0]     sample_count;
  logic [GAIN_W-1:0]    gain_pulses;
  logic [HP_W-1:0]      half_period_ticks;
  logic [DATA_BITS-1:0] timeout_ticks;
  logic [DATA_BITS-1:0] gap_ticks;

  // sequencing state
  phase_t               phase, phase_next;
  logic [DATA_BITS-1:0] tick_counter, tick_counter_next;
  logic [PULSE_W-1:0]   pulse_counter, pulse_counter_next;
  logic [DATA_BITS-1:0] shift_word, shift_word_next;
  logic [CNT_W-1:0]     readings_left, readings_left_next;
  logic [SUM_W-1:0]     running_sum, running_sum_next;
  logic                 timeout_seen, timeout_seen_next;
  logic [DATA_BITS-1:0] held_average;
  logic                 res_flag;

  // divider
  logic [SUM_W-1:0]     div_q;
  logic [CNT_W-1:0]     div_r;
  logic [DIV_CNT_W-1:0] div_cnt;
  logic [CNT_W:0]       div_sh;
  logic                 div_bit;
  logic [SUM_W-1:0]     div_q_next;
  logic [CNT_W-1:0]     divisor;

  logic [HP_W-1:0]      half;
  logic [DATA_BITS-1:0] tc_inc;
  logic [PULSE_W-1:0]   pc_inc;
  logic [DATA_BITS-1:0] sw_shift;
  logic                 half_done;
  logic                 finish;
  logic                 rd_done;
  logic [DATA_BITS-1:0] rd_value;

  assign half      = (half_period_ticks == '0) ? HP_W'(1) : half_period_ticks;
  assign half_done = tick_counter >= {{(DATA_BITS-HP_W){1'b0}}, half};
  assign tc_inc    = tick_counter + DATA_BITS'(1);
  assign pc_inc    = pulse_counter + PULSE_W'(1);
  assign sw_shift  = {shift_word[DATA_BITS-2:0], in_data.dout};
  assign divisor   = (sample_count == '0) ? CNT_W'(1) : sample_count;

  always_comb begin
    phase_next         = phase;
    tick_counter_next  = tick_counter;
    pulse_counter_next = pulse_counter;
    shift_word_next    = shift_word;
    readings_left_next = readings_left;
    running_sum_next   = running_sum;
    timeout_seen_next  = timeout_seen;
    finish             = 1'b0;
    rd_done            = 1'b0;
    rd_value           = '0;
    case (phase)
      PH_IDLE: begin
        if (in_data.start_req) begin
          readings_left_next = divisor;
          running_sum_next   = '0;
          timeout_seen_next  = 1'b0;
          tick_counter_next  = '0;
          phase_next         = PH_WAIT;
        end
      end
      PH_WAIT: begin
        if (!in_data.dout) begin
          phase_next         = PH_DHIGH;
          tick_counter_next  = DATA_BITS'(1);
          pulse_counter_next = '0;
          shift_word_next    = '0;
        end else begin
          tick_counter_next = tc_inc;
          if (tc_inc >= timeout_ticks) begin
            timeout_seen_next = 1'b1;
            rd_done           = 1'b1;
          end
        end
      end
      PH_DHIGH, PH_GHIGH: begin
        if (half_done) begin
          phase_next        = (phase == PH_DHIGH) ? PH_DLOW : PH_GLOW;
          tick_counter_next = DATA_BITS'(1);
        end else begin
          tick_counter_next = tc_inc;
        end
      end
      PH_DLOW: begin
        if (half_done) begin
          tick_counter_next  = DATA_BITS'(1);
          shift_word_next    = sw_shift;
          pulse_counter_next = pc_inc;
          if (pc_inc >= LAST_BIT) begin
            shift_word_next    = sw_shift ^ FLIP_MASK;
            pulse_counter_next = '0;
            if (gain_pulses == '0) begin
              rd_done  = 1'b1;
              rd_value = sw_shift ^ FLIP_MASK;
            end else begin
              phase_next = PH_GHIGH;
            end
          end else begin
            phase_next = PH_DHIGH;
          end
        end else begin
          tick_counter_next = tc_inc;
        end
      end
      PH_GLOW: begin
        if (half_done) begin
          pulse_counter_next = pc_inc;
          tick_counter_next  = DATA_BITS'(1);
          if (pc_inc >= {{(PULSE_W-GAIN_W){1'b0}}, gain_pulses}) begin
            rd_done  = 1'b1;
            rd_value = shift_word;
          end else begin
            phase_next = PH_GHIGH;
          end
        end else begin
          tick_counter_next = tc_inc;
        end
      end
      PH_GAP: begin
        if (tick_counter >= gap_ticks) begin
          tick_counter_next = '0;
          if (readings_left == '0) begin
            finish     = 1'b1;
            phase_next = PH_IDLE;
          end else begin
            phase_next = PH_WAIT;
          end
        end else begin
          tick_counter_next = tc_inc;
        end
      end
      default: begin
        phase_next        = PH_IDLE;
        tick_counter_next = '0;
      end
    endcase
    // a reading ends: accumulate and go to the gap
    if (rd_done) begin
      running_sum_next   = running_sum + {{(SUM_W-DATA_BITS){1'b0}}, rd_value};
      readings_left_next = readings_left - CNT_W'(1);
      phase_next         = PH_GAP;
      tick_counter_next  = '0;
    end
  end

  assign status.finish   = finish;
  assign status.div_last = div_cnt == DIV_LAST;

  // restoring divide, one quotient bit per cycle; remainder stays below divisor
  assign div_sh     = {div_r, div_q[SUM_W-1]};
  assign div_bit    = div_sh >= {1'b0, divisor};
  assign div_q_next = {div_q[SUM_W-2:0], div_bit};

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_count      <= CNT_W'(1);
      gain_pulses       <= GAIN_W'(1);
      half_period_ticks <= HP_W'(4);
      timeout_ticks     <= DATA_BITS'(150000);
      gap_ticks         <= DATA_BITS'(5000);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SAMPLE_COUNT: sample_count      <= cfg_data[CNT_W-1:0];
        CFG_GAIN_PULSES:  gain_pulses       <= cfg_data[GAIN_W-1:0];
        CFG_HALF_PERIOD:  half_period_ticks <= cfg_data[HP_W-1:0];
        CFG_TIMEOUT:      timeout_ticks     <= cfg_data[DATA_BITS-1:0];
        CFG_GAP:          gap_ticks         <= cfg_data[DATA_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      tick_counter  <= '0;
      pulse_counter <= '0;
      shift_word    <= '0;
      readings_left <= '0;
      running_sum   <= '0;
      timeout_seen  <= 1'b0;
      held_average  <= '0;
      res_flag      <= 1'b0;
    end else begin
      if (cmd.step) begin
        phase         <= phase_next;
        tick_counter  <= tick_counter_next;
        pulse_counter <= pulse_counter_next;
        shift_word    <= shift_word_next;
        readings_left <= readings_left_next;
        running_sum   <= running_sum_next;
        timeout_seen  <= timeout_seen_next;
        res_flag      <= finish;
      end
      if (cmd.div_run && status.div_last) begin
        held_average <= (div_q_next[SUM_W-1:DATA_BITS] != '0) ? MAX24
                                                              : div_q_next[DATA_BITS-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.step && finish) begin
      div_q   <= running_sum;
      div_r   <= '0;
      div_cnt <= '0;
    end else if (cmd.div_run) begin
      div_q   <= div_q_next;
      div_r   <= div_bit ? CNT_W'(div_sh - {1'b0, divisor}) : div_sh[CNT_W-1:0];
      div_cnt <= div_cnt + DIV_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data.sck          <= (phase == PH_DHIGH) || (phase == PH_GHIGH);
      out_data.busy_res     <= phase != PH_IDLE;
      out_data.result_valid <= res_flag;
      out_data.average      <= held_average;
      out_data.any_timeout  <= timeout_seen;
    end
  end

  `BAVG_ASSERT(a_div_when_idle, !cmd.div_run || phase == PH_IDLE, "divide outside idle phase")
  `BAVG_ASSERT_NEXT(a_finish_clears_cnt, cmd.step && finish, div_cnt == '0 && phase == PH_IDLE, "divide not armed")
  `BAVG_ASSERT(a_pulse_range, pulse_counter < LAST_BIT, "pulse counter past data bits")

endmodule
`default_nettype wire

[bench/bridge_adc_serial_readout_average_test.sv]
`timescale 1ns / 1ps

// Bench for the bridge ADC readout/averaging block.
// Every input beat is one timebase tick and produces exactly one output beat.
// The bench keeps its own cycle-free copy of the readout sequencer and checks
// every output beat against it in order.
module bridge_adc_serial_readout_average_test;
  import bavg_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 600000;
  // A closing tick runs the 40-step divider, so let it finish before a
  // register write or the final verdict.
  localparam int unsigned SETTLE_CYCLES = 48;
  localparam int unsigned RANDOM_TICKS = 500;

  logic                  clk;
  logic                  rst = 1'b1;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  in_beat_t              in_data = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_beat_t             out_data;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  bridge_adc_serial_readout_average i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Predictor state: register copies and sequencer state, reset values.
  // ---------------------------------------------------------------------------
  logic [15:0] c_samples = 16'd1;
  logic [1:0]  c_gain    = 2'd1;
  logic [9:0]  c_half    = 10'd4;
  logic [23:0] c_tmo     = 24'd150000;
  logic [23:0] c_gap     = 24'd5000;

  phase_t      ph       = PH_IDLE;
  logic [23:0] tcount   = '0;
  logic [4:0]  pcount   = '0;
  logic [23:0] shreg    = '0;
  logic [15:0] left     = '0;
  logic [39:0] acc      = '0;
  logic        tflag    = 1'b0;
  logic [23:0] avg_hold = '0;

  // Ticks waiting to be driven, and output beats predicted for accepted ticks.
  in_beat_t    pending_ticks[$];
  out_beat_t   expected_beats[$];
  out_beat_t   predicted_beat;
  out_beat_t   monitor_want;

  int unsigned cycle_count    = 0;
  int unsigned mismatch_count = 0;
  int unsigned pushed_ticks   = 0;
  int unsigned beats_checked  = 0;
  int unsigned averages_seen  = 0;
  int unsigned timeout_runs   = 0;
  int unsigned settings_used  = 0;
  logic        quiet          = 1'b0;  // no idling on either side while set

  task automatic report_error(input string msg);
    mismatch_count++;
    if (mismatch_count <= 30) $display("[%0t] error: %s", $time, msg);
  endtask

  // A reading is finished: accumulate, count down, enter the gap.
  task automatic close_reading(input logic [23:0] value);
    acc    = acc + {16'd0, value};
    left   = left - 16'd1;
    ph     = PH_GAP;
    tcount = '0;
  endtask

  // One timebase tick through the sequencer; returns the beat it produces.
  task automatic readout_step(input in_beat_t b, output out_beat_t r);
    logic [9:0]  half;
    logic [39:0] quo;
    logic [15:0] divisor;
    logic        fired;
    half  = (c_half == 10'd0) ? 10'd1 : c_half;
    fired = 1'b0;
    case (ph)
      PH_IDLE: begin
        if (b.start_req) begin
          // count of readings is latched here; zero means one reading
          left   = (c_samples == 16'd0) ? 16'd1 : c_samples;
          acc    = '0;
          tflag  = 1'b0;
          tcount = '0;
          ph     = PH_WAIT;
        end
      end
      PH_WAIT: begin
        if (!b.dout) begin
          ph     = PH_DHIGH;
          tcount = 24'd1;
          pcount = '0;
          shreg  = '0;
        end else begin
          tcount = tcount + 24'd1;
          if (tcount >= c_tmo) begin
            tflag = 1'b1;
            close_reading('0);
          end
        end
      end
      PH_DHIGH, PH_GHIGH: begin
        if (tcount >= half) begin
          ph     = (ph == PH_DHIGH) ? PH_DLOW : PH_GLOW;
          tcount = 24'd1;
        end else begin
          tcount = tcount + 24'd1;
        end
      end
      PH_DLOW: begin
        if (tcount >= half) begin
          shreg  = {shreg[22:0], b.dout};
          pcount = pcount + 5'd1;
          tcount = 24'd1;
          if (pcount >= DATA_BITS) begin
            shreg  = shreg ^ FLIP_MASK;  // two's complement to offset binary
            pcount = '0;
            if (c_gain == 2'd0) close_reading(shreg);
            else ph = PH_GHIGH;
          end else begin
            ph = PH_DHIGH;
          end
        end else begin
          tcount = tcount + 24'd1;
        end
      end
      PH_GLOW: begin
        if (tcount >= half) begin
          pcount = pcount + 5'd1;
          tcount = 24'd1;
          if (pcount >= c_gain) close_reading(shreg);
          else ph = PH_GHIGH;
        end else begin
          tcount = tcount + 24'd1;
        end
      end
      PH_GAP: begin
        if (tcount >= c_gap) begin
          tcount = '0;
          if (left == 16'd0) begin
            // divisor is whatever the register holds now, zero taken as one
            divisor  = (c_samples == 16'd0) ? 16'd1 : c_samples;
            quo      = acc / {24'd0, divisor};
            avg_hold = (quo > {16'd0, MAX24}) ? MAX24 : quo[23:0];
            fired    = 1'b1;
            ph       = PH_IDLE;
          end else begin
            ph = PH_WAIT;
          end
        end else begin
          tcount = tcount + 24'd1;
        end
      end
      default: begin
        ph     = PH_IDLE;
        tcount = '0;
      end
    endcase
    r.sck          = (ph == PH_DHIGH) || (ph == PH_GHIGH);
    r.busy_res     = (ph != PH_IDLE);
    r.result_valid = fired;
    r.average      = avg_hold;
    r.any_timeout  = tflag;
  endtask

  // ---------------------------------------------------------------------------
  // Driver: presents pending ticks, predicts each beat as it is accepted.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        readout_step(in_data, predicted_beat);
        expected_beats.push_back(predicted_beat);
      end
      // a stalled beat holds; otherwise load the next one or idle
      if (!in_valid || !in_stall) begin
        if (pending_ticks.size() != 0 && (quiet || $urandom_range(0, 99) >= 6)) begin
          in_data  <= pending_ticks.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: random back-pressure, in-order compare of every output beat.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (expected_beats.size() == 0) begin
        report_error("output beat with nothing expected");
      end else begin
        monitor_want = expected_beats.pop_front();
        if (out_data.sck !== monitor_want.sck)
          report_error($sformatf("beat %0d sck %b, want %b", beats_checked,
                                 out_data.sck, monitor_want.sck));
        if (out_data.busy_res !== monitor_want.busy_res)
          report_error($sformatf("beat %0d busy_res %b, want %b", beats_checked,
                                 out_data.busy_res, monitor_want.busy_res));
        if (out_data.result_valid !== monitor_want.result_valid)
          report_error($sformatf("beat %0d result_valid %b, want %b", beats_checked,
                                 out_data.result_valid, monitor_want.result_valid));
        if (out_data.average !== monitor_want.average)
          report_error($sformatf("beat %0d average %h, want %h", beats_checked,
                                 out_data.average, monitor_want.average));
        if (out_data.any_timeout !== monitor_want.any_timeout)
          report_error($sformatf("beat %0d any_timeout %b, want %b", beats_checked,
                                 out_data.any_timeout, monitor_want.any_timeout));
        beats_checked++;
        if (monitor_want.result_valid) begin
          averages_seen++;
          if (monitor_want.any_timeout) timeout_runs++;
        end
      end
    end
    out_stall <= !rst && !quiet && ($urandom_range(0, 99) < 6);
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("timeout after %0d cycles, %0d beats still expected", cycle_count,
             expected_beats.size());
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers. They work from the bench's register copies, which match
  // the block since writes only happen with nothing in flight.
  // ---------------------------------------------------------------------------
  task automatic push_tick(input logic d, input logic s);
    in_beat_t t;
    t.dout      = d;
    t.start_req = s;
    pending_ticks.push_back(t);
    pushed_ticks++;
  endtask

  // Ticks whose data line level does not matter; a rare start lands while busy.
  task automatic push_filler(input int n);
    repeat (n) push_tick(1'($urandom_range(0, 1)), $urandom_range(0, 15) == 0);
  endtask

  task automatic push_noise(input int n);
    repeat (n) push_tick(1'($urandom_range(0, 1)), $urandom_range(0, 3) == 0);
  endtask

  // One well-formed reading that yields the given offset-binary value:
  // a few not-ready ticks, data ready, 24 clocked bits, gain pulses, gap.
  task automatic push_value_reading(input logic [23:0] value);
    logic [23:0] bits;
    int          h;
    int          k;
    int          i;
    h    = (c_half == 10'd0) ? 1 : c_half;
    bits = value ^ FLIP_MASK;
    k    = (c_tmo <= 24'd1) ? 0 : $urandom_range(0, (c_tmo - 1 < 6) ? c_tmo - 1 : 6);
    repeat (k) push_tick(1'b1, 1'b0);
    push_tick(1'b0, 1'b0);
    // each bit: high level then low level, sampled on the last low tick
    for (i = 23; i >= 0; i--) begin
      push_filler(2 * h - 1);
      push_tick(bits[i], 1'b0);
    end
    push_filler(2 * h * c_gain + c_gap + 1);
  endtask

  // Data line held high until the reading gives up, then the gap.
  task automatic push_timeout_reading();
    repeat ((c_tmo == 24'd0) ? 1 : c_tmo) push_tick(1'b1, 1'b0);
    push_filler(c_gap + 1);
  endtask

  // Start request plus as many readings as the current count asks for.
  task automatic push_run();
    int          n;
    logic [23:0] v;
    n = (c_samples == 16'd0) ? 1 : c_samples;
    push_tick(1'($urandom_range(0, 1)), 1'b1);
    repeat (n) begin
      if (c_tmo <= 24'd40 && $urandom_range(0, 4) == 0) begin
        push_timeout_reading();
      end else begin
        case ($urandom_range(0, 7))
          0:       v = '0;
          1:       v = MAX24;
          2:       v = FLIP_MASK;
          3:       v = FLIP_MASK - 24'd1;
          default: v = 24'($urandom());
        endcase
        push_value_reading(v);
      end
    end
  endtask

  // Wait until every tick is driven and every beat checked, then let the
  // divider finish before touching registers.
  task automatic settle();
    do @(negedge clk);
    while (pending_ticks.size() != 0 || in_valid || expected_beats.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [23:0] data);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    case (idx)
      CFG_SAMPLE_COUNT: c_samples = data[15:0];
      CFG_GAIN_PULSES:  c_gain    = data[1:0];
      CFG_HALF_PERIOD:  c_half    = data[9:0];
      CFG_TIMEOUT:      c_tmo     = data;
      CFG_GAP:          c_gap     = data;
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic apply_setting(input logic [15:0] sc, input logic [1:0] g,
                               input logic [9:0] hp, input logic [23:0] tmo,
                               input logic [23:0] gap);
    write_reg(CFG_SAMPLE_COUNT, {8'd0, sc});
    write_reg(CFG_GAIN_PULSES, {22'd0, g});
    write_reg(CFG_HALF_PERIOD, {14'd0, hp});
    write_reg(CFG_TIMEOUT, tmo);
    write_reg(CFG_GAP, gap);
    settings_used++;
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned mark;
    int unsigned random_ticks;
    int unsigned round_no;
    random_ticks = 0;
    round_no     = 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // idle ticks against the reset defaults
    push_tick(1'b0, 1'b0);
    push_tick(1'b1, 1'b0);
    push_tick(1'b0, 1'b0);
    settle();

    // all-zero registers: half period acts as one, first high tick times out,
    // no gain pulses, a zero count takes one reading
    apply_setting(16'd0, 2'd0, 10'd0, 24'd0, 24'd0);
    push_tick(1'b0, 1'b0);
    push_tick(1'b1, 1'b1);
    push_tick(1'b1, 1'b0);
    push_tick(1'b1, 1'b1);   // gap closes the run; start here is ignored
    push_tick(1'b1, 1'b1);
    push_tick(1'b1, 1'b1);   // start while busy
    push_tick(1'b0, 1'b0);
    push_tick(1'b0, 1'b1);
    push_value_reading(MAX24);
    settle();

    // count raised to the maximum mid-run: divisor follows the register
    apply_setting(16'd2, 2'd1, 10'd1, 24'd30, 24'd0);
    push_tick(1'b0, 1'b1);
    push_value_reading(24'($urandom()));
    settle();
    write_reg(CFG_SAMPLE_COUNT, 24'd65535);
    push_value_reading(MAX24);
    settle();

    // count dropped to zero mid-run: quotient overflows and saturates
    apply_setting(16'd3, 2'd2, 10'd1, 24'd30, 24'd1);
    push_tick(1'b1, 1'b1);
    push_value_reading(MAX24);
    push_value_reading(MAX24);
    settle();
    write_reg(CFG_SAMPLE_COUNT, 24'd0);
    push_value_reading(MAX24);
    settle();

    // random settings, mostly well-formed runs, some noise
    while (random_ticks < RANDOM_TICKS) begin
      apply_setting(16'($urandom_range(0, 3)), 2'($urandom_range(0, 3)),
                    10'(($urandom_range(0, 7) == 0) ? $urandom_range(2, 3)
                                                    : $urandom_range(0, 1)),
                    24'($urandom_range(0, 40)), 24'($urandom_range(0, 4)));
      quiet = (round_no == 2);
      mark  = pushed_ticks;
      while (pushed_ticks - mark < 100) begin
        case ($urandom_range(0, 9))
          0:       push_noise($urandom_range(1, 8));
          1:       repeat ($urandom_range(1, 4)) push_tick(1'($urandom_range(0, 1)), 1'b0);
          default: push_run();
        endcase
      end
      random_ticks += pushed_ticks - mark;
      settle();
      quiet = 1'b0;
      round_no++;
    end

    // register maxima; a run this slow cannot finish, only its start is seen
    apply_setting(16'd65535, 2'd3, 10'd1023, 24'hFFFFFF, 24'hFFFFFF);
    push_tick(1'b1, 1'b1);
    push_noise(200);
    settle();

    if (expected_beats.size() != 0)
      report_error($sformatf("%0d predicted beats never arrived", expected_beats.size()));
    $display("checked %0d tick beats over %0d register settings", beats_checked,
             settings_used);
    $display("%0d averages completed, %0d with a timed-out reading; %0d errors",
             averages_seen, timeout_runs, mismatch_count);
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
